// ===== src/fcsg_pkg.sv =====
// Shared constants for the filled circle span generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package fcsg_pkg;

	// Command codes on the input channel.
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam int COORD_W = 16;
	localparam int COLOR_W = 16;

	// Row limit is r * ROW_NUM / ROW_DEN + 1 (about r / sqrt(2)).
	localparam int ROW_NUM = 707;
	localparam int ROW_DEN = 1000;

	// One row step yields at most four spans.
	localparam int SLOTS      = 4;
	localparam int SLOT_CNT_W = $clog2(SLOTS + 1);

endpackage

`default_nettype wire

// ===== src/fcsg_span_queue.sv =====
// Span queue: takes a batch of up to SLOTS spans at once and hands them out
// one per transaction, head always registered. Depends on fcsg_pkg.
`default_nettype none

module fcsg_span_queue
	import fcsg_pkg::*;
#(
	parameter int DATA_W = 62
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               load,
	input  wire logic [SLOTS-1:0][DATA_W-1:0]       load_data,
	input  wire logic [SLOT_CNT_W-1:0]              load_count,
	output logic                                    load_ok,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [DATA_W-1:0]                       out_data
);

	logic [SLOTS-1:0][DATA_W-1:0] slot_q;
	logic [SLOT_CNT_W-1:0]        count_q;
	logic                         pop;

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[0];
	assign pop       = out_valid && out_ready;
	// a new batch may land once the queue is empty or its last span leaves now
	assign load_ok   = (count_q == '0) || ((count_q == SLOT_CNT_W'(1)) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= load_count;
		end else if (pop) begin
			count_q <= count_q - SLOT_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= load_data;
		end else if (pop) begin
			for (int k = 0; k < SLOTS - 1; k++) begin
				slot_q[k] <= slot_q[k+1];
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/fcsg_row_step.sv =====
// Circle state and one midpoint row step per item; squares kept incrementally.
// Produces a packed batch of spans. Depends on fcsg_pkg.
`default_nettype none

module fcsg_row_step
	import fcsg_pkg::*;
#(
	parameter int RADIUS_BITS = 12,
	localparam int SPAN_W = 2 * COORD_W + RADIUS_BITS + 1 + COLOR_W + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic                          command,
	input  wire logic [COORD_W-1:0]            center_x,
	input  wire logic [COORD_W-1:0]            center_y,
	input  wire logic [RADIUS_BITS-1:0]        radius,
	input  wire logic [COLOR_W-1:0]            fill_color,
	output logic [SLOTS-1:0][SPAN_W-1:0]       spans,
	output logic [SLOT_CNT_W-1:0]              span_count
);

	localparam int R     = RADIUS_BITS;
	localparam int SQ_W  = 2 * R;
	localparam int SHIFT = R + 10;
	// ceil(ROW_NUM * 2^SHIFT / ROW_DEN): exact floor for every R-bit radius
	localparam logic [SHIFT-1:0] ROW_MUL = SHIFT'(((longint'(ROW_NUM) << SHIFT)
		+ longint'(ROW_DEN) - 64'sd1) / longint'(ROW_DEN));

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [R:0]         length;
		logic [COLOR_W-1:0] color;
		logic               last;
	} span_t;

	logic [COORD_W-1:0] origin_x_q, origin_y_q, held_color_q;
	logic [R-1:0]       row_step_q, half_width_q, row_limit_q;
	logic [SQ_W-1:0]    square_limit_q, step_sq_q, width_sq_q;
	logic               busy_q;

	logic [COORD_W-1:0] origin_x_d, origin_y_d, held_color_d;
	logic [R-1:0]       row_step_d, half_width_d, row_limit_d;
	logic [SQ_W-1:0]    square_limit_d, step_sq_d, width_sq_d;
	logic               busy_d, update;

	// start path
	logic [SQ_W-1:0]    r_sq;
	logic [R+SHIFT-1:0] lim_prod;

	// row step path
	logic [R-1:0]       i_next, x_new;
	logic [SQ_W-1:0]    i_sq_next, x_sq_new;
	logic [SQ_W:0]      sq_sum;
	logic               over, shrink, outer_ok, inner_ok, done;

	span_t start_span, o_hi, o_lo, i_hi, i_lo;
	span_t [SLOTS-1:0] slot;

	assign r_sq     = SQ_W'(radius) * SQ_W'(radius);
	assign lim_prod = (R + SHIFT)'(radius) * (R + SHIFT)'(ROW_MUL);

	assign i_next    = row_step_q + R'(1);
	assign i_sq_next = step_sq_q + SQ_W'({row_step_q, 1'b1});
	assign sq_sum    = {1'b0, i_sq_next} + {1'b0, width_sq_q};
	assign over      = sq_sum > {1'b0, square_limit_q};
	assign shrink    = over && (half_width_q != '0);
	assign x_new     = shrink ? half_width_q - R'(1) : half_width_q;
	assign x_sq_new  = shrink ? width_sq_q - SQ_W'({half_width_q, 1'b0}) + SQ_W'(1)
	                          : width_sq_q;
	// outer rows have length 2*row_step, empty on the first step
	assign outer_ok  = over && (half_width_q > row_limit_q) && (row_step_q != '0);
	assign inner_ok  = (x_new != '0);
	assign done      = (i_next >= row_limit_q);

	always_comb begin
		start_span.x      = center_x - COORD_W'(radius);
		start_span.y      = center_y;
		start_span.length = {radius, 1'b0};
		start_span.color  = fill_color;
		start_span.last   = (radius == R'(1));

		o_hi.x      = origin_x_q - COORD_W'(row_step_q);
		o_hi.y      = origin_y_q + COORD_W'(half_width_q);
		o_hi.length = {row_step_q, 1'b0};
		o_hi.color  = held_color_q;
		o_hi.last   = 1'b0;
		o_lo        = o_hi;
		o_lo.y      = origin_y_q - COORD_W'(half_width_q);

		i_hi.x      = origin_x_q - COORD_W'(x_new);
		i_hi.y      = origin_y_q + COORD_W'(i_next);
		i_hi.length = {x_new, 1'b0};
		i_hi.color  = held_color_q;
		i_hi.last   = 1'b0;
		i_lo        = i_hi;
		i_lo.y      = origin_y_q - COORD_W'(i_next);
	end

	always_comb begin
		origin_x_d     = origin_x_q;
		origin_y_d     = origin_y_q;
		held_color_d   = held_color_q;
		row_step_d     = row_step_q;
		half_width_d   = half_width_q;
		row_limit_d    = row_limit_q;
		square_limit_d = square_limit_q;
		step_sq_d      = step_sq_q;
		width_sq_d     = width_sq_q;
		busy_d         = busy_q;
		update         = 1'b0;
		slot           = {i_lo, i_hi, i_lo, i_hi};
		span_count     = '0;

		if (command == CMD_START) begin
			update         = 1'b1;
			origin_x_d     = center_x;
			origin_y_d     = center_y;
			held_color_d   = fill_color;
			row_step_d     = '0;
			half_width_d   = radius;
			row_limit_d    = lim_prod[R+SHIFT-1:SHIFT] + R'(1);
			square_limit_d = r_sq + SQ_W'(radius >> 1);
			step_sq_d      = '0;
			width_sq_d     = r_sq;
			busy_d         = (radius > R'(1));
			slot[0]        = start_span;
			span_count     = (radius != '0) ? SLOT_CNT_W'(1) : '0;
		end else if (busy_q) begin
			update       = 1'b1;
			row_step_d   = i_next;
			half_width_d = x_new;
			step_sq_d    = i_sq_next;
			width_sq_d   = x_sq_new;
			busy_d       = !done;
			if (outer_ok) begin
				slot = {i_lo, i_hi, o_lo, o_hi};
				if (inner_ok) begin
					span_count   = SLOT_CNT_W'(4);
					slot[3].last = done;
				end else begin
					span_count   = SLOT_CNT_W'(2);
					slot[1].last = done;
				end
			end else if (inner_ok) begin
				span_count   = SLOT_CNT_W'(2);
				slot[1].last = done;
			end
		end
	end

	assign spans = slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			held_color_q   <= '0;
			row_step_q     <= '0;
			half_width_q   <= '0;
			row_limit_q    <= '0;
			square_limit_q <= '0;
			step_sq_q      <= '0;
			width_sq_q     <= '0;
			busy_q         <= 1'b0;
		end else if (load && update) begin
			origin_x_q     <= origin_x_d;
			origin_y_q     <= origin_y_d;
			held_color_q   <= held_color_d;
			row_step_q     <= row_step_d;
			half_width_q   <= half_width_d;
			row_limit_q    <= row_limit_d;
			square_limit_q <= square_limit_d;
			step_sq_q      <= step_sq_d;
			width_sq_q     <= width_sq_d;
			busy_q         <= busy_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/filled_circle_span_generator_core.sv =====
// Filled circle span generator, top level. Uses fcsg_pkg, fcsg_row_step, fcsg_span_queue.
// Path: an accepted item waits in the input stage until the span queue can take its whole
//   batch; its first span is then offered from the registered queue head.
// Throughput: an item yields 0, 1, 2 or 4 spans; the single result channel drains the span
//   queue one span a cycle while out_ready is high; a new batch loads as the last leaves.
// Reset: arst_n asynchronous, active low; clears circle state, queue and stage valid.
`default_nettype none

module filled_circle_span_generator_core
	import fcsg_pkg::*;
#(
	parameter int RADIUS_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input channel
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   command,
	input  wire logic [COORD_W-1:0]     center_x,
	input  wire logic [COORD_W-1:0]     center_y,
	input  wire logic [RADIUS_BITS-1:0] radius,
	input  wire logic [COLOR_W-1:0]     fill_color,
	// result channel
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [COORD_W-1:0]          span_x,
	output logic [COORD_W-1:0]          span_y,
	output logic [RADIUS_BITS:0]        span_length,
	output logic [COLOR_W-1:0]          span_color,
	output logic                        span_last
);

	localparam int SPAN_W = 2 * COORD_W + RADIUS_BITS + 1 + COLOR_W + 1;

	// same layout as the span batch built in the row step
	typedef struct packed {
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [RADIUS_BITS:0] length;
		logic [COLOR_W-1:0]   color;
		logic                 last;
	} span_t;

	// Input stage: holds one item while the queue still drains the spans of
	// the previous one; upstream waits only while the held item cannot fire.
	logic                   valid_s1;
	logic                   command_s1;
	logic [COORD_W-1:0]     center_x_s1, center_y_s1;
	logic [RADIUS_BITS-1:0] radius_s1;
	logic [COLOR_W-1:0]     fill_color_s1;

	logic                          load_ok, fire;
	logic [SLOTS-1:0][SPAN_W-1:0]  spans;
	logic [SLOT_CNT_W-1:0]         span_count;
	logic [SPAN_W-1:0]             head_bits;
	span_t                         head;

	// the held item executes once the queue can take its whole batch
	assign fire     = valid_s1 && load_ok;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1    <= command;
			center_x_s1   <= center_x;
			center_y_s1   <= center_y;
			radius_s1     <= radius;
			fill_color_s1 <= fill_color;
		end
	end

	// Circle state and the midpoint row step; state advances on fire.
	fcsg_row_step #(
		.RADIUS_BITS(RADIUS_BITS)
	) u_row_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire),
		.command    (command_s1),
		.center_x   (center_x_s1),
		.center_y   (center_y_s1),
		.radius     (radius_s1),
		.fill_color (fill_color_s1),
		.spans      (spans),
		.span_count (span_count)
	);

	// Batch of up to four spans, handed out one transaction at a time.
	fcsg_span_queue #(
		.DATA_W(SPAN_W)
	) u_span_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire),
		.load_data  (spans),
		.load_count (span_count),
		.load_ok    (load_ok),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (head_bits)
	);

	assign head        = span_t'(head_bits);
	assign span_x      = head.x;
	assign span_y      = head.y;
	assign span_length = head.length;
	assign span_color  = head.color;
	assign span_last   = head.last;

endmodule

`default_nettype wire
